/* rtl/itd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the incremental tree diameter block.
// No dependencies; imported by the ancestor RAM and the top level.
package itd_pkg;

  localparam int MAX_NODES = 4096;
  localparam int LEVELS    = 12;
  localparam int ROWS      = MAX_NODES + 1;
  localparam int NODE_W    = 13;
  localparam int DEP_W     = 12;
  localparam int LVL_W     = $clog2(LEVELS + 1);
  localparam int ANC_DEPTH = ROWS * LEVELS;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);

  // One ancestor entry: the ancestor's index and that ancestor's depth.
  typedef struct packed {
    logic [DEP_W-1:0]  dep;
    logic [NODE_W-1:0] node;
  } anc_word_t;

  // Access request from the sequencer to the ancestor RAM.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] wnode;
    logic [LVL_W-1:0]  wlevel;
    anc_word_t         wdata;
    logic [NODE_W-1:0] rnode;
    logic [LVL_W-1:0]  rlevel;
  } anc_req_t;

endpackage

/* rtl/itd_anc_ram.sv */
`timescale 1ns / 1ps
// Ancestor table RAM: one write and one registered read per cycle.
// Depends on itd_pkg. Rows of node 0 and the root read as zero.
module itd_anc_ram (
  input  logic              clk,
  input  itd_pkg::anc_req_t req,
  output itd_pkg::anc_word_t rd_word
);
  import itd_pkg::*;

  anc_word_t         mem [0:ANC_DEPTH-1];
  anc_word_t         q_r;
  logic              zero_r;
  logic [ANC_AW-1:0] waddr;
  logic [ANC_AW-1:0] raddr;

  // Row-major address: node times the row length plus the level.
  assign waddr = ANC_AW'(req.wnode) * ANC_AW'(LEVELS) + ANC_AW'(req.wlevel);
  assign raddr = ANC_AW'(req.rnode) * ANC_AW'(LEVELS) + ANC_AW'(req.rlevel);

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= req.wdata;
    end
  end

  // Read port with a flag for the rows that are zero by definition.
  always_ff @(posedge clk) begin
    q_r    <= mem[raddr];
    zero_r <= (req.rnode <= NODE_W'(1));
  end

  assign rd_word = zero_r ? '0 : q_r;

endmodule

/* rtl/incremental_tree_diameter_top.sv */
`timescale 1ns / 1ps
// Top level of the incremental tree diameter block: sequencer and state.
// Depends on itd_pkg and itd_anc_ram.
//
// Channel   Ports                                   Handshake
// input     in_parent_node                          start, busy
// result    out_diameter, out_rejected              out_valid (one cycle)
//
// A rejected request gives its result in the cycle after acceptance.
// An accepted node keeps busy high through a row build of LEVELS entries, two ancestor
// searches and one update step, all set by the single read port of the ancestor RAM.
// The result comes in the first cycle with busy low, which can take the next request.
// Reset is synchronous and active low; the RAM itself is not cleared.
// The receiver cannot stall; busy is high while a node is being processed.
module incremental_tree_diameter_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [itd_pkg::NODE_W-1:0] in_parent_node,
  output logic                      out_valid,
  output logic [itd_pkg::DEP_W-1:0] out_diameter,
  output logic                      out_rejected
);
  import itd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_ROW0 = 10'b0000000010,
    S_ROW  = 10'b0000000100,
    S_LSET = 10'b0000001000,
    S_LUP  = 10'b0000010000,
    S_LCHK = 10'b0000100000,
    S_LA   = 10'b0001000000,
    S_LB   = 10'b0010000000,
    S_LTOP = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] count_r, count_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [NODE_W-1:0] par_r, par_nxt;
  logic [DEP_W-1:0]  ndep_r, ndep_nxt;
  logic [NODE_W-1:0] ep1_r, ep1_nxt, ep2_r, ep2_nxt;
  logic [DEP_W-1:0]  ep1_dep_r, ep1_dep_nxt, ep2_dep_r, ep2_dep_nxt;
  logic [DEP_W-1:0]  best_r, best_nxt;
  logic [LVL_W-1:0]  k_r, k_nxt;
  logic [NODE_W-1:0] a_r, a_nxt, b_r, b_nxt, ua_r, ua_nxt;
  logic [DEP_W-1:0]  db_r, db_nxt;
  logic [DEP_W:0]    dsum_r, dsum_nxt;
  logic              pass_r, pass_nxt;
  logic [DEP_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DEP_W-1:0]  out_diam_r, out_diam_nxt;
  logic              out_rej_r, out_rej_nxt;

  anc_req_t          req;
  anc_word_t         rd;

  logic              reject;
  logic [DEP_W-1:0]  pdep;
  logic [NODE_W-1:0] ea, anew, bnew;
  logic [DEP_W-1:0]  eda, dc, path_len, bl;
  logic              finish;

  itd_anc_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_word (rd)
  );

  assign reject = (in_parent_node == '0) || (in_parent_node > count_r) ||
                  (count_r >= NODE_W'(MAX_NODES));

  // Sequencer: rejects bad requests, or builds the new row, runs two ancestor searches, updates.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    node_nxt      = node_r;
    par_nxt       = par_r;
    ndep_nxt      = ndep_r;
    ep1_nxt       = ep1_r;
    ep2_nxt       = ep2_r;
    ep1_dep_nxt   = ep1_dep_r;
    ep2_dep_nxt   = ep2_dep_r;
    best_nxt      = best_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ua_nxt        = ua_r;
    db_nxt        = db_r;
    dsum_nxt      = dsum_r;
    pass_nxt      = pass_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = 1'b0;
    out_diam_nxt  = out_diam_r;
    out_rej_nxt   = out_rej_r;
    req           = '0;
    pdep          = '0;
    ea            = pass_r ? ep2_r : ep1_r;
    eda           = pass_r ? ep2_dep_r : ep1_dep_r;
    anew          = a_r;
    bnew          = b_r;
    dc            = '0;
    finish        = 1'b0;
    bl            = best_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (reject) begin
            out_valid_nxt = 1'b1;
            out_diam_nxt  = best_r;
            out_rej_nxt   = 1'b1;
          end else begin
            node_nxt   = count_r + NODE_W'(1);
            par_nxt    = in_parent_node;
            req.rnode  = in_parent_node;
            req.rlevel = '0;
            state_nxt  = S_ROW0;
          end
        end
      end
      S_ROW0: begin
        // The parent's depth is one more than the depth of its own parent.
        pdep           = (par_r == NODE_W'(1)) ? '0 : rd.dep + DEP_W'(1);
        ndep_nxt       = pdep + DEP_W'(1);
        req.we         = 1'b1;
        req.wnode      = node_r;
        req.wlevel     = '0;
        req.wdata.dep  = pdep;
        req.wdata.node = par_r;
        req.rnode      = par_r;
        req.rlevel     = '0;
        k_nxt          = LVL_W'(1);
        pass_nxt       = 1'b0;
        state_nxt      = (LEVELS > 1) ? S_ROW : S_LSET;
      end
      S_ROW: begin
        req.we     = 1'b1;
        req.wnode  = node_r;
        req.wlevel = k_r;
        req.wdata  = rd;
        req.rnode  = rd.node;
        req.rlevel = k_r;
        if (k_r == LVL_W'(LEVELS - 1)) begin
          state_nxt = S_LSET;
        end else begin
          k_nxt = k_r + LVL_W'(1);
        end
      end
      S_LSET: begin
        // The deeper node is lifted; the shallower one stays as the target.
        if (eda < ndep_r) begin
          a_nxt  = node_r;
          b_nxt  = ea;
          db_nxt = eda;
        end else begin
          a_nxt  = ea;
          b_nxt  = node_r;
          db_nxt = ndep_r;
        end
        dsum_nxt   = {1'b0, eda} + {1'b0, ndep_r};
        k_nxt      = LVL_W'(LEVELS - 1);
        req.rnode  = a_nxt;
        req.rlevel = LVL_W'(LEVELS - 1);
        state_nxt  = S_LUP;
      end
      S_LUP: begin
        if (rd.dep >= db_r) begin
          anew = rd.node;
        end
        a_nxt = anew;
        if (k_r == '0) begin
          state_nxt = S_LCHK;
        end else begin
          k_nxt      = k_r - LVL_W'(1);
          req.rnode  = anew;
          req.rlevel = k_r - LVL_W'(1);
        end
      end
      S_LCHK: begin
        if (a_r == b_r) begin
          dc     = db_r;
          finish = 1'b1;
        end else begin
          k_nxt      = LVL_W'(LEVELS - 1);
          req.rnode  = a_r;
          req.rlevel = LVL_W'(LEVELS - 1);
          state_nxt  = S_LA;
        end
      end
      S_LA: begin
        ua_nxt     = rd.node;
        req.rnode  = b_r;
        req.rlevel = k_r;
        state_nxt  = S_LB;
      end
      S_LB: begin
        // Both climb together while their ancestors still differ.
        if (ua_r != rd.node) begin
          anew = ua_r;
          bnew = rd.node;
        end
        a_nxt     = anew;
        b_nxt     = bnew;
        req.rnode = anew;
        if (k_r == '0) begin
          req.rlevel = '0;
          state_nxt  = S_LTOP;
        end else begin
          k_nxt      = k_r - LVL_W'(1);
          req.rlevel = k_r - LVL_W'(1);
          state_nxt  = S_LA;
        end
      end
      S_LTOP: begin
        dc     = rd.dep;
        finish = 1'b1;
      end
      S_FIN: begin
        if (x_r > bl) begin
          ep2_nxt     = node_r;
          ep2_dep_nxt = ndep_r;
          bl          = x_r;
        end
        if (y_r > bl) begin
          ep1_nxt     = node_r;
          ep1_dep_nxt = ndep_r;
          bl          = y_r;
        end
        best_nxt      = bl;
        count_nxt     = node_r;
        out_valid_nxt = 1'b1;
        out_diam_nxt  = bl;
        out_rej_nxt   = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Path length from the common ancestor's depth.
    path_len = DEP_W'(dsum_r - {dc, 1'b0});
    if (finish) begin
      if (!pass_r) begin
        x_nxt     = path_len;
        pass_nxt  = 1'b1;
        state_nxt = S_LSET;
      end else begin
        y_nxt     = path_len;
        state_nxt = S_FIN;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= NODE_W'(1);
      ep1_r       <= NODE_W'(1);
      ep2_r       <= NODE_W'(2);
      ep1_dep_r   <= '0;
      ep2_dep_r   <= DEP_W'(1);
      best_r      <= DEP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ep1_r       <= ep1_nxt;
      ep2_r       <= ep2_nxt;
      ep1_dep_r   <= ep1_dep_nxt;
      ep2_dep_r   <= ep2_dep_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    par_r      <= par_nxt;
    ndep_r     <= ndep_nxt;
    k_r        <= k_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ua_r       <= ua_nxt;
    db_r       <= db_nxt;
    dsum_r     <= dsum_nxt;
    pass_r     <= pass_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    out_diam_r <= out_diam_nxt;
    out_rej_r  <= out_rej_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_diameter = out_diam_r;
  assign out_rejected = out_rej_r;

`ifndef ASSERT_OFF
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy) else $error("result shown while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid_r || busy)) else $error("request dropped");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rej_r) |-> (count_r == $past(count_r) + NODE_W'(1)))
    else $error("node count did not advance");

  a_diam_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_diam_r == best_r)) else $error("diameter mismatch");
`endif

endmodule

/* tb/tb_incremental_tree_diameter_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the incremental tree diameter block.
// Depends on itd_pkg and incremental_tree_diameter_top; nothing else.
module tb_incremental_tree_diameter_top;
  import itd_pkg::*;

  localparam int HOLD  = -1;   // queue marker: wait until every result has come
  localparam int LIMIT = 4000; // idle cycles allowed before the watchdog fires

  typedef struct {
    logic [DEP_W-1:0] diameter;
    logic             rejected;
  } tree_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [NODE_W-1:0] in_parent_node = '0;
  logic              busy;
  logic              out_valid;
  logic [DEP_W-1:0]  out_diameter;
  logic              out_rejected;

  int           pending_parents[$];
  tree_result_t diameter_queue[$];
  logic         took = 1'b0;
  int           n_accepted = 0;
  int           n_errors = 0;
  int           quiet_cycles = 0;

  // Shadow of the tree: depths, binary-lifting rows and the diameter endpoints.
  logic [DEP_W-1:0]  depth_mem[0:ROWS-1];
  logic [NODE_W-1:0] lift_mem[0:ROWS-1][0:LEVELS-1];
  int                tree_size = 1;
  int                end_a = 1;
  int                end_b = 2;
  int                best_len = 1;

  incremental_tree_diameter_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_parent_node(in_parent_node), .out_valid(out_valid),
    .out_diameter(out_diameter), .out_rejected(out_rejected)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic int lift(input int node, input int lvl);
    if (node >= ROWS) return 0;
    return lift_mem[node][lvl];
  endfunction

  function automatic int node_depth(input int node);
    if (node >= ROWS) return 0;
    return depth_mem[node];
  endfunction

  // Distance in edges between two nodes through their lowest common ancestor.
  function automatic int tree_distance(input int a, input int b);
    int x, y, t, ux, uy, lca;
    x = a;
    y = b;
    if (node_depth(x) < node_depth(y)) begin
      t = x; x = y; y = t;
    end
    for (int k = LEVELS - 1; k >= 0; k--) begin
      ux = lift(x, k);
      if (node_depth(ux) >= node_depth(y)) x = ux;
    end
    if (x == y) begin
      lca = x;
    end else begin
      for (int k = LEVELS - 1; k >= 0; k--) begin
        ux = lift(x, k);
        uy = lift(y, k);
        if (ux != uy) begin
          x = ux; y = uy;
        end
      end
      lca = lift(x, 0);
    end
    return node_depth(a) + node_depth(b) - 2 * node_depth(lca);
  endfunction

  // Attach one node and work out the diameter that the block should report.
  task automatic grow_tree(input int parent, output tree_result_t res);
    int node, d1, d2;
    if (parent == 0 || parent > tree_size || tree_size >= MAX_NODES) begin
      res.diameter = best_len[DEP_W-1:0];
      res.rejected = 1'b1;
      return;
    end
    node = tree_size + 1;
    depth_mem[node] = node_depth(parent) + 1;
    lift_mem[node][0] = parent;
    for (int k = 1; k < LEVELS; k++)
      lift_mem[node][k] = lift(lift(node, k - 1), k - 1);
    d1 = tree_distance(end_a, node);
    d2 = tree_distance(end_b, node);
    if (d1 > best_len) begin
      end_b = node; best_len = d1;
    end
    if (d2 > best_len) begin
      end_a = node; best_len = d2;
    end
    tree_size = node;
    res.diameter = best_len[DEP_W-1:0];
    res.rejected = 1'b0;
  endtask

  // Monitor: takes requests and results at the rising edge and checks them.
  always @(posedge clk) begin
    tree_result_t exp_res;
    tree_result_t got;
    logic acc;
    acc = rst_n && start && !busy;
    took <= acc;
    if (acc) begin
      grow_tree(int'(in_parent_node), exp_res);
      diameter_queue.push_back(exp_res);
      n_accepted++;
    end
    if (rst_n && out_valid) begin
      if (diameter_queue.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        got = diameter_queue.pop_front();
        if (out_diameter !== got.diameter)
          report($sformatf("diameter %0d, expected %0d", out_diameter, got.diameter));
        if (out_rejected !== got.rejected)
          report($sformatf("rejected %0b, expected %0b", out_rejected, got.rejected));
      end
    end
    quiet_cycles = (acc || (rst_n && out_valid)) ? 0 : quiet_cycles + 1;
  end

  // Driver: offers the next pending request at the falling edge.
  always @(negedge clk) begin
    int idle_pct;
    logic offer;
    if (took) void'(pending_parents.pop_front());
    if (pending_parents.size() > 0 && pending_parents[0] == HOLD &&
        diameter_queue.size() == 0)
      void'(pending_parents.pop_front());
    if (n_accepted < 250) idle_pct = 31;
    else if (n_accepted < 500) idle_pct = 49;
    else idle_pct = 0;
    if (!rst_n || pending_parents.size() == 0 || pending_parents[0] == HOLD) begin
      offer = 1'b0;
    end else if (start && !took) begin
      offer = 1'b1;
    end else begin
      offer = ($urandom_range(99) >= idle_pct);
    end
    start <= offer;
    if (offer) in_parent_node <= pending_parents[0][NODE_W-1:0];
  end

  // Builds the request list, tracking how many nodes the tree will hold.
  initial begin
    int gc;
    int p;
    int directed[15];
    directed = '{0, 8191, 2, 1, 1, 2, 3, 4, 6, 5, 4096, 5000, 4097, 7, 1};
    for (int i = 0; i < ROWS; i++) begin
      depth_mem[i] = '0;
      for (int k = 0; k < LEVELS; k++) lift_mem[i][k] = '0;
    end
    gc = 1;
    // Directed part: absent parents, the first node, a short chain, extremes.
    foreach (directed[i]) begin
      p = directed[i];
      pending_parents.push_back(p);
      if (p >= 1 && p <= gc && gc < MAX_NODES) gc++;
    end
    // Random part: mostly valid parents, often near the newest nodes.
    for (int i = 0; i < 730; i++) begin
      if (i == 300) pending_parents.push_back(HOLD);
      if ($urandom_range(99) < 20) begin
        p = $urandom_range(8191);
      end else if ($urandom_range(1)) begin
        p = gc - $urandom_range((gc > 4) ? 3 : gc - 1);
      end else begin
        p = $urandom_range(gc, 1);
      end
      pending_parents.push_back(p);
      if (p >= 1 && p <= gc && gc < MAX_NODES) gc++;
    end
    // Finish with a valid parent and two absent ones far above the tree size.
    pending_parents.push_back(1);
    pending_parents.push_back(MAX_NODES);
    pending_parents.push_back(8191);

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_parents.size() == 0 && diameter_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0)
      $display("[incremental_tree_diameter_top] OK");
    else
      $display("[incremental_tree_diameter_top] ERROR");
    $finish;
  end

  // Watchdog: too long with nothing accepted on either side.
  always @(posedge clk) begin
    if (quiet_cycles >= LIMIT) begin
      $display("[incremental_tree_diameter_top] ERROR");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/itd_pkg.sv
rtl/itd_anc_ram.sv
rtl/incremental_tree_diameter_top.sv
tb/tb_incremental_tree_diameter_top.sv
